FILE: rtl/core/bde_pkg.sv
// ----------------------------------------------------------------------------
// bde_pkg: shared types for the bounded deque engine
// Opcodes, status codes, operation kinds and the controller/datapath link.
// ----------------------------------------------------------------------------
package bde_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 32;

	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_INSERT     = 3'd4,
		OP_ERASE      = 3'd5,
		OP_READ       = 3'd6,
		OP_CLEAR      = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// how the store is touched by an accepted request
	typedef enum logic [2:0] {
		K_NONE,
		K_APPEND,
		K_GAP,
		K_CLOSE,
		K_READ
	} kind_t;

	typedef struct packed {
		logic load;
		logic start;
		logic mv_rd;
		logic pos_rd;
		logic val_wr;
		logic commit;
	} bde_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  no_moves;
		logic  last;
	} bde_stat_t;

endpackage

FILE: rtl/core/bde_ctrl.sv
// ----------------------------------------------------------------------------
// bde_ctrl: deque engine controller
// Sequences decode, element moves, reads and result hand-off.
// ----------------------------------------------------------------------------
module bde_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  bde_pkg::bde_stat_t stat,
	output bde_pkg::bde_cmd_t  cmd
);
	import bde_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_MOVE,
		S_DRAIN,
		S_WRITE,
		S_RDWAIT,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.start  = (state_q == S_DECODE);
		cmd.val_wr = ((state_q == S_DECODE) && (stat.kind == K_APPEND)) || (state_q == S_WRITE);
		cmd.pos_rd = (state_q == S_DECODE) && (stat.kind == K_READ);
		cmd.mv_rd  = (state_q == S_MOVE);
		cmd.commit = (state_q == S_FINISH) && slot_free;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_nx = S_DECODE;
			end
			S_DECODE: begin
				case (stat.kind)
					K_GAP:   state_nx = stat.no_moves ? S_WRITE : S_MOVE;
					K_CLOSE: state_nx = stat.no_moves ? S_FINISH : S_MOVE;
					K_READ:  state_nx = S_RDWAIT;
					default: state_nx = S_FINISH;
				endcase
			end
			S_MOVE: begin
				if (stat.last)
					state_nx = S_DRAIN;
			end
			S_DRAIN:  state_nx = (stat.kind == K_GAP) ? S_WRITE : S_FINISH;
			S_WRITE:  state_nx = S_FINISH;
			S_RDWAIT: state_nx = S_FINISH;
			S_FINISH: begin
				if (slot_free)
					state_nx = S_IDLE;
			end
			default:  state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/core/bde_datapath.sv
// ----------------------------------------------------------------------------
// bde_datapath: deque engine datapath
// Element store, request decode, move addressing and result registers.
// ----------------------------------------------------------------------------
module bde_datapath #(
	parameter int CAPACITY   = bde_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = bde_pkg::DEF_DATA_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bde_pkg::bde_cmd_t             cmd,
	output bde_pkg::bde_stat_t            stat,
	input  logic [2:0]                    opcode,
	input  logic [$clog2(CAPACITY+1)-1:0] position,
	input  logic [$clog2(CAPACITY+1)-1:0] run_count,
	input  logic [DATA_WIDTH-1:0]         data_in,
	output logic [1:0]                    status,
	output logic [DATA_WIDTH-1:0]         data_out,
	output logic [$clog2(CAPACITY+1)-1:0] length
);
	import bde_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	logic [DATA_WIDTH-1:0] mem [CAPACITY];

	opcode_t               op_q;
	logic [CW-1:0]         pos_q;
	logic [CW-1:0]         run_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         src_q;
	logic [CW-1:0]         end_q;
	logic [AW-1:0]         dst_s1;
	logic                  mv_vld_s1;
	logic [DATA_WIDTH-1:0] rdata_q;
	logic [1:0]            status_q;
	logic [DATA_WIDTH-1:0] data_out_q;
	logic [CW-1:0]         length_q;

	status_t       st_c;
	kind_t         kind_c;
	logic [CW-1:0] len_nx;
	logic [CW-1:0] gap_at;
	logic [CW-1:0] cl_pos;
	logic [CW-1:0] cl_run;
	logic [CW:0]   span;
	logic [CW:0]   cl_span;
	logic [CW:0]   n_ext;
	logic          full;
	logic          empty;
	logic [CW-1:0] dst_gap;
	logic [CW-1:0] dst_close;

	assign n_ext   = {1'b0, count_q};
	assign span    = {1'b0, pos_q} + {1'b0, run_q};
	assign cl_span = {1'b0, cl_pos} + {1'b0, cl_run};
	assign full    = (count_q == CAP_C);
	assign empty   = (count_q == '0);

	always_comb begin
		st_c   = ST_OK;
		kind_c = K_NONE;
		len_nx = count_q;
		gap_at = count_q;
		cl_pos = pos_q;
		cl_run = run_q;
		case (op_q)
			OP_PUSH_BACK: begin
				if (full) begin
					st_c = ST_FULL;
				end else begin
					kind_c = K_APPEND;
					len_nx = count_q + ONE_C;
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					st_c = ST_FULL;
				end else begin
					kind_c = K_GAP;
					gap_at = '0;
					len_nx = count_q + ONE_C;
				end
			end
			OP_POP_BACK: begin
				if (empty)
					st_c = ST_EMPTY;
				else
					len_nx = count_q - ONE_C;
			end
			OP_POP_FRONT: begin
				if (empty) begin
					st_c = ST_EMPTY;
				end else begin
					kind_c = K_CLOSE;
					cl_pos = '0;
					cl_run = ONE_C;
					len_nx = count_q - ONE_C;
				end
			end
			OP_INSERT: begin
				if (pos_q == '0 || pos_q > count_q) begin
					st_c = ST_RANGE;
				end else if (full) begin
					st_c = ST_FULL;
				end else begin
					kind_c = K_GAP;
					gap_at = pos_q;
					len_nx = count_q + ONE_C;
				end
			end
			OP_ERASE: begin
				if (empty) begin
					st_c = ST_EMPTY;
				end else if (span > n_ext) begin
					st_c = ST_RANGE;
				end else if (run_q != '0) begin
					kind_c = K_CLOSE;
					len_nx = count_q - run_q;
				end
			end
			OP_READ: begin
				if (empty)
					st_c = ST_EMPTY;
				else if (pos_q >= count_q)
					st_c = ST_RANGE;
				else
					kind_c = K_READ;
			end
			OP_CLEAR: len_nx = '0;
			default:  len_nx = count_q;
		endcase
	end

	assign stat.kind     = kind_c;
	assign stat.no_moves = (kind_c == K_GAP) ? (count_q == gap_at) : (cl_span == n_ext);
	assign stat.last     = (src_q == end_q);

	assign dst_gap   = src_q + ONE_C;
	assign dst_close = src_q - cl_run;

	// request capture, move addressing, count and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode_t'(opcode);
			pos_q  <= position;
			run_q  <= run_count;
			data_q <= data_in;
		end
		if (cmd.start) begin
			if (kind_c == K_GAP) begin
				src_q <= count_q - ONE_C;
				end_q <= gap_at;
			end else begin
				src_q <= cl_span[CW-1:0];
				end_q <= count_q - ONE_C;
			end
		end else if (cmd.mv_rd) begin
			src_q <= (kind_c == K_GAP) ? (src_q - ONE_C) : (src_q + ONE_C);
		end
		if (cmd.mv_rd)
			dst_s1 <= (kind_c == K_GAP) ? dst_gap[AW-1:0] : dst_close[AW-1:0];
		if (cmd.commit) begin
			status_q   <= st_c;
			length_q   <= len_nx;
			data_out_q <= (kind_c == K_READ) ? rdata_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_vld_s1 <= 1'b0;
			count_q   <= '0;
		end else begin
			mv_vld_s1 <= cmd.mv_rd;
			if (cmd.commit)
				count_q <= len_nx;
		end
	end

	// element store: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (mv_vld_s1)
			mem[dst_s1] <= rdata_q;
		else if (cmd.val_wr)
			mem[gap_at[AW-1:0]] <= data_q;
		if (cmd.mv_rd)
			rdata_q <= mem[src_q[AW-1:0]];
		else if (cmd.pos_rd)
			rdata_q <= mem[pos_q[AW-1:0]];
	end

	assign status   = status_q;
	assign data_out = data_out_q;
	assign length   = length_q;

endmodule

FILE: rtl/core/bounded_deque_engine_core.sv
// ----------------------------------------------------------------------------
// bounded_deque_engine_core: bounded double-ended queue of data words
// Push/pop at either end, insert, erase run, read at position and clear.
// ----------------------------------------------------------------------------
//  channel  handshake           beat fields
//  in       in_valid/in_stall   opcode, position, run_count, data_in
//  out      out_valid/out_stall status, data_out, length
//
//  One request at a time; the input stalls from acceptance until the result
//  is loaded into the output register, which may still wait while the next
//  beat is accepted. Push back, pop back, clear and errors go from decode to
//  finish; read passes a read-wait state. Push front and insert pass a write
//  state, and pop front and erase go to finish; with elements to shift, each
//  first moves them in the move state and then drains. The longest request
//  is push front onto CAPACITY - 1 words. A stalled result holds the finishing
//  request. Reset empties the queue; stored words are not cleared.
module bounded_deque_engine_core #(
	parameter int CAPACITY   = bde_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = bde_pkg::DEF_DATA_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    opcode,
	input  logic [$clog2(CAPACITY+1)-1:0] position,
	input  logic [$clog2(CAPACITY+1)-1:0] run_count,
	input  logic [DATA_WIDTH-1:0]         data_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [DATA_WIDTH-1:0]         data_out,
	output logic [$clog2(CAPACITY+1)-1:0] length
);
	import bde_pkg::*;

	bde_cmd_t  cmd;
	bde_stat_t stat;

	bde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	bde_datapath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.opcode    (opcode),
		.position  (position),
		.run_count (run_count),
		.data_in   (data_in),
		.status    (status),
		.data_out  (data_out),
		.length    (length)
	);

endmodule
